// ===== hdl/teimu_pkg.sv =====
// Shared types and constants for the user-side TEI management block.
// Holds the item, result and configuration structs and the message codes.
// No dependencies.
`default_nettype none

package teimu_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS  = 2'd1;

	localparam logic [15:0] RETRY_TIMEOUT_RESET = 16'd2000;
	localparam logic [3:0]  MAX_ATTEMPTS_RESET  = 4'd3;

	localparam logic [6:0] BROADCAST_TEI = 7'd127;
	localparam logic [7:0] MGMT_ENTITY   = 8'h0f;
	localparam logic [7:0] UI_MASK       = 8'hef;
	localparam logic [7:0] UI_CONTROL    = 8'h03;

	typedef enum logic [2:0] {
		OP_ASSIGN_IND = 3'd0,
		OP_TICK       = 3'd1,
		OP_RX_FRAME   = 3'd2,
		OP_STATIC     = 3'd3,
		OP_LOCAL_REM  = 3'd4
	} opcode_t;

	// Received message types, Q.921 numbering.
	localparam logic [7:0] MT_ID_ASSIGNED = 8'd2;
	localparam logic [7:0] MT_CHECK_REQ   = 8'd4;
	localparam logic [7:0] MT_REMOVE      = 8'd6;

	// Outgoing message types.
	localparam logic [2:0] OMT_NONE      = 3'd0;
	localparam logic [2:0] OMT_ID_REQ    = 3'd1;
	localparam logic [2:0] OMT_CHECK_RSP = 3'd5;

	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_SEND_REQ  = 3'd1,
		ACT_CHECK_RSP = 3'd2,
		ACT_ASSIGN    = 3'd3,
		ACT_REMOVE    = 3'd4,
		ACT_ERROR     = 3'd5,
		ACT_DROPPED   = 3'd6
	} action_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  msg_type;
		logic [15:0] ref_number;
		logic [6:0]  ai_value;
		logic [7:0]  control_byte;
		logic [7:0]  entity_id;
		logic        too_short;
		logic [15:0] random_ri;
	} item_t;

	typedef struct packed {
		action_t     action;
		logic [2:0]  out_msg_type;
		logic [15:0] out_ri;
		logic [6:0]  out_ai;
		logic        tei_assigned;
		logic [6:0]  current_tei;
		logic        request_pending;
	} result_t;

	typedef struct packed {
		logic [15:0] retry_timeout;
		logic [3:0]  max_attempts;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hdl/teimu_cfg.sv =====
// Configuration registers: retry timeout and attempt limit.
// Depends on teimu_pkg.
`default_nettype none

module teimu_cfg
	import teimu_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_timeout <= RETRY_TIMEOUT_RESET;
			cfg_q.max_attempts  <= MAX_ATTEMPTS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RETRY_TIMEOUT: cfg_q.retry_timeout <= cfg_wdata[15:0];
				CFG_MAX_ATTEMPTS:  cfg_q.max_attempts  <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/teimu_core.sv =====
// Endpoint state and per-event logic: decodes one item, forms its result and
// updates the TEI, pending request, attempt count and retry timer.
// Depends on teimu_pkg.
`default_nettype none

module teimu_core
	import teimu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step_en,
	input  item_t     item,
	input  cfg_t      cfg,
	output result_t   res
);

	logic        assigned_q, assigned_d;
	logic [6:0]  held_tei_q, held_tei_d;
	logic        pending_q, pending_d;
	logic [15:0] saved_ri_q, saved_ri_d;
	logic [3:0]  attempt_q, attempt_d;
	logic        timer_run_q, timer_run_d;
	logic [15:0] timer_left_q, timer_left_d;

	logic    frame_ok;
	logic    names_me;
	logic    send_req;
	action_t act;
	logic [2:0]  omt;
	logic [15:0] ori;
	logic [6:0]  oai;

	assign frame_ok = !item.too_short
		&& ((item.control_byte & UI_MASK) == UI_CONTROL)
		&& (item.entity_id == MGMT_ENTITY);
	assign names_me = assigned_q
		&& ((item.ai_value == BROADCAST_TEI) || (item.ai_value == held_tei_q));

	always_comb begin
		assigned_d   = assigned_q;
		held_tei_d   = held_tei_q;
		pending_d    = pending_q;
		saved_ri_d   = saved_ri_q;
		attempt_d    = attempt_q;
		timer_run_d  = timer_run_q;
		timer_left_d = timer_left_q;
		send_req     = 1'b0;
		act          = ACT_NONE;
		omt          = OMT_NONE;
		ori          = '0;
		oai          = '0;

		case (item.opcode)
			OP_ASSIGN_IND: begin
				attempt_d    = 4'd1;
				timer_run_d  = 1'b1;
				timer_left_d = cfg.retry_timeout;
				pending_d    = 1'b1;
				assigned_d   = 1'b0;
				held_tei_d   = BROADCAST_TEI;
				send_req     = 1'b1;
			end
			OP_TICK: begin
				if (timer_run_q) begin
					if (timer_left_q > 16'd1) begin
						timer_left_d = timer_left_q - 16'd1;
					end else if (attempt_q >= cfg.max_attempts) begin
						// give up: drop the request and flag it
						assigned_d   = 1'b0;
						held_tei_d   = BROADCAST_TEI;
						pending_d    = 1'b0;
						saved_ri_d   = '0;
						timer_run_d  = 1'b0;
						timer_left_d = '0;
						act          = ACT_ERROR;
					end else begin
						attempt_d    = attempt_q + 4'd1;
						timer_left_d = cfg.retry_timeout;
						send_req     = 1'b1;
					end
				end
			end
			OP_RX_FRAME: begin
				if (!frame_ok) begin
					act = ACT_DROPPED;
				end else begin
					case (item.msg_type)
						MT_ID_ASSIGNED: begin
							if (assigned_q && (item.ai_value == held_tei_q)) begin
								// duplicate TEI on the link: drop ours
								assigned_d = 1'b0;
								held_tei_d = BROADCAST_TEI;
								act        = ACT_REMOVE;
							end else if (pending_q && (item.ref_number == saved_ri_q)) begin
								pending_d    = 1'b0;
								saved_ri_d   = '0;
								held_tei_d   = item.ai_value;
								assigned_d   = 1'b1;
								timer_run_d  = 1'b0;
								timer_left_d = '0;
								act          = ACT_ASSIGN;
								oai          = item.ai_value;
							end
						end
						MT_CHECK_REQ: begin
							if (names_me) begin
								act = ACT_CHECK_RSP;
								omt = OMT_CHECK_RSP;
								ori = item.random_ri;
								oai = held_tei_q;
							end
						end
						MT_REMOVE: begin
							if (names_me) begin
								assigned_d = 1'b0;
								held_tei_d = BROADCAST_TEI;
								act        = ACT_REMOVE;
							end
						end
						default: ;
					endcase
				end
			end
			OP_STATIC: begin
				pending_d    = 1'b0;
				saved_ri_d   = '0;
				held_tei_d   = item.ai_value;
				assigned_d   = 1'b1;
				timer_run_d  = 1'b0;
				timer_left_d = '0;
				act          = ACT_ASSIGN;
				oai          = item.ai_value;
			end
			OP_LOCAL_REM: begin
				if (names_me) begin
					assigned_d = 1'b0;
					held_tei_d = BROADCAST_TEI;
					act        = ACT_REMOVE;
				end
			end
			default: ;
		endcase

		if (send_req) begin
			saved_ri_d = item.random_ri;
			act        = ACT_SEND_REQ;
			omt        = OMT_ID_REQ;
			ori        = item.random_ri;
			oai        = BROADCAST_TEI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assigned_q   <= 1'b0;
			held_tei_q   <= BROADCAST_TEI;
			pending_q    <= 1'b0;
			saved_ri_q   <= '0;
			attempt_q    <= '0;
			timer_run_q  <= 1'b0;
			timer_left_q <= '0;
		end else if (step_en) begin
			assigned_q   <= assigned_d;
			held_tei_q   <= held_tei_d;
			pending_q    <= pending_d;
			saved_ri_q   <= saved_ri_d;
			attempt_q    <= attempt_d;
			timer_run_q  <= timer_run_d;
			timer_left_q <= timer_left_d;
		end
	end

	always_comb begin
		res.action          = act;
		res.out_msg_type    = omt;
		res.out_ri          = ori;
		res.out_ai          = oai;
		res.tei_assigned    = assigned_d;
		res.current_tei     = held_tei_d;
		res.request_pending = pending_d;
	end

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(assigned_q && pending_q))
		else $error("TEI assigned while a request is still pending");

	a_unassigned_tei: assert property (@(posedge clk) disable iff (!arst_n)
		!assigned_q |-> (held_tei_q == BROADCAST_TEI))
		else $error("held TEI not broadcast while unassigned");

	a_timer_tracks_pending: assert property (@(posedge clk) disable iff (!arst_n)
		timer_run_q == pending_q)
		else $error("retry timer out of step with pending request");

endmodule

`default_nettype wire

// ===== hdl/tei_management_user_side.sv =====
// Top level of user-side TEI management for one LAPD endpoint.
// Holds the input register and result register; instantiates teimu_cfg and
// teimu_core. Depends on teimu_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | to block  | in_valid/in_stall  | opcode, msg_type, ref_number, ...
//  out     | from block| out_valid/out_stall| action, out_msg_type, out_ri, ...
//  cfg     | to block  | cfg_we             | cfg_index, cfg_wdata
//
// One item per clock sustained while out_stall stays low; an item's result enters
// the result register when the item leaves the input register, where the event
// logic of the core settles, and can then transfer out.
// Reset loads the timeout (2000) and attempt limit (3) and clears the
// endpoint to unassigned, TEI 127, nothing pending.
// A stalled result holds in the result register; the input register still
// takes one more item, and in_stall rises only when both are full.
`default_nettype none

module tei_management_user_side
	import teimu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  opcode,
	input  wire logic [7:0]  msg_type,
	input  wire logic [15:0] ref_number,
	input  wire logic [6:0]  ai_value,
	input  wire logic [7:0]  control_byte,
	input  wire logic [7:0]  entity_id,
	input  wire logic        too_short,
	input  wire logic [15:0] random_ri,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       action,
	output logic [2:0]       out_msg_type,
	output logic [15:0]      out_ri,
	output logic [6:0]       out_ai,
	output logic             tei_assigned,
	output logic [6:0]       current_tei,
	output logic             request_pending
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	teimu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Move the held item into the result register whenever that register
	// is empty or its result is being taken this cycle.
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Input register: load on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.opcode       <= opcode;
			item_s1.msg_type     <= msg_type;
			item_s1.ref_number   <= ref_number;
			item_s1.ai_value     <= ai_value;
			item_s1.control_byte <= control_byte;
			item_s1.entity_id    <= entity_id;
			item_s1.too_short    <= too_short;
			item_s1.random_ri    <= random_ri;
		end
	end

	// The core commits its state only when the item really moves on, so a
	// stalled item is evaluated again against unchanged state.
	teimu_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (valid_s1 && advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Result register: hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign action          = res_s2.action;
	assign out_msg_type    = res_s2.out_msg_type;
	assign out_ri          = res_s2.out_ri;
	assign out_ai          = res_s2.out_ai;
	assign tei_assigned    = res_s2.tei_assigned;
	assign current_tei     = res_s2.current_tei;
	assign request_pending = res_s2.request_pending;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a full pipeline");

	a_request_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (action == ACT_SEND_REQ)) |->
			((out_ai == BROADCAST_TEI) && (out_msg_type == OMT_ID_REQ)))
		else $error("identity request with wrong message fields");

	a_assign_reports_tei: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (action == ACT_ASSIGN)) |->
			(tei_assigned && (current_tei == out_ai) && !request_pending))
		else $error("assign result disagrees with endpoint state");

endmodule

`default_nettype wire

// ===== tb/tei_management_user_side_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for tei_management_user_side: directed and random events,
// predicted results checked field by field. Depends on teimu_pkg and the block's RTL.

module tei_management_user_side_tb;
	import teimu_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 6;
	localparam int N_PHASES       = 8;
	localparam int EVENTS_PER_PHASE = 175;
	localparam int QUIET_LIMIT    = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 10;

	// No opcode beyond local remove is defined; the block must ignore these.
	localparam logic [2:0] OP_UNDEFINED = 3'd7;

	// Timer load and attempt limit per phase; phase 0 runs on the reset values.
	localparam logic [15:0] PHASE_TIMEOUT [N_PHASES] =
		'{16'd2000, 16'd1, 16'd3, 16'd0, 16'd65535, 16'd2, 16'd4, 16'd1};
	localparam logic [3:0] PHASE_ATTEMPTS [N_PHASES] =
		'{4'd3, 4'd1, 4'd15, 4'd0, 4'd15, 4'd2, 4'd5, 4'd15};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  opcode = '0;
	logic [7:0]  msg_type = '0;
	logic [15:0] ref_number = '0;
	logic [6:0]  ai_value = '0;
	logic [7:0]  control_byte = '0;
	logic [7:0]  entity_id = '0;
	logic        too_short = 1'b0;
	logic [15:0] random_ri = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  action;
	logic [2:0]  out_msg_type;
	logic [15:0] out_ri;
	logic [6:0]  out_ai;
	logic        tei_assigned;
	logic [6:0]  current_tei;
	logic        request_pending;

	// Endpoint state as the testbench sees it, plus its copy of the registers.
	logic        holds_tei = 1'b0;
	logic [6:0]  own_tei = BROADCAST_TEI;
	logic        pending_req = 1'b0;
	logic [15:0] req_ri = '0;
	logic [3:0]  n_attempts = '0;
	logic        timer_on = 1'b0;
	logic [15:0] ticks_left = '0;
	logic [15:0] retry_ticks = RETRY_TIMEOUT_RESET;
	logic [3:0]  attempt_limit = MAX_ATTEMPTS_RESET;

	item_t   queued_events[$];
	result_t awaited_actions[$];
	item_t   driven_event;

	// Small pools so that Ri values and TEIs recur and the matching paths fire.
	logic [15:0] ri_pool [4];
	logic [6:0]  tei_pool [4];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int results_seen = 0;
	int events_sent = 0;
	int quiet_cycles = 0;

	tei_management_user_side dut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic void drop_tei();
		holds_tei = 1'b0;
		own_tei = BROADCAST_TEI;
	endfunction

	function automatic void take_tei(input logic [6:0] tei);
		pending_req = 1'b0;
		req_ri = '0;
		own_tei = tei;
		holds_tei = 1'b1;
		timer_on = 1'b0;
		ticks_left = '0;
	endfunction

	// A check request or remove names us when we hold a TEI and it is ours or broadcast.
	function automatic logic addressed(input logic [6:0] ai);
		return holds_tei && (ai == BROADCAST_TEI || ai == own_tei);
	endfunction

	function automatic result_t tei_response(input item_t ev);
		result_t r;
		logic    send_req;
		r = '0;
		r.action = ACT_NONE;
		send_req = 1'b0;
		case (ev.opcode)
			OP_ASSIGN_IND: begin
				n_attempts = 4'd1;
				timer_on = 1'b1;
				ticks_left = retry_ticks;
				pending_req = 1'b1;
				drop_tei();
				send_req = 1'b1;
			end
			OP_TICK: begin
				// A stopped timer ignores ticks; one or zero left means expiry.
				if (timer_on) begin
					if (ticks_left > 16'd1) begin
						ticks_left = ticks_left - 16'd1;
					end else if (n_attempts >= attempt_limit) begin
						drop_tei();
						pending_req = 1'b0;
						req_ri = '0;
						timer_on = 1'b0;
						ticks_left = '0;
						r.action = ACT_ERROR;
					end else begin
						n_attempts = n_attempts + 4'd1;
						ticks_left = retry_ticks;
						send_req = 1'b1;
					end
				end
			end
			OP_RX_FRAME: begin
				if (ev.too_short || (ev.control_byte & UI_MASK) != UI_CONTROL ||
						ev.entity_id != MGMT_ENTITY) begin
					r.action = ACT_DROPPED;
				end else if (ev.msg_type == MT_ID_ASSIGNED) begin
					// Someone else got our TEI: give it up, leave pending and timer alone.
					if (holds_tei && ev.ai_value == own_tei) begin
						drop_tei();
						r.action = ACT_REMOVE;
					end else if (pending_req && ev.ref_number == req_ri) begin
						take_tei(ev.ai_value);
						r.action = ACT_ASSIGN;
						r.out_ai = own_tei;
					end
				end else if (ev.msg_type == MT_CHECK_REQ) begin
					if (addressed(ev.ai_value)) begin
						r.action = ACT_CHECK_RSP;
						r.out_msg_type = OMT_CHECK_RSP;
						r.out_ri = ev.random_ri;
						r.out_ai = own_tei;
					end
				end else if (ev.msg_type == MT_REMOVE) begin
					if (addressed(ev.ai_value)) begin
						drop_tei();
						r.action = ACT_REMOVE;
					end
				end
			end
			OP_STATIC: begin
				take_tei(ev.ai_value);
				r.action = ACT_ASSIGN;
				r.out_ai = own_tei;
			end
			OP_LOCAL_REM: begin
				if (addressed(ev.ai_value)) begin
					drop_tei();
					r.action = ACT_REMOVE;
				end
			end
			default: ;
		endcase
		if (send_req) begin
			req_ri = ev.random_ri;
			r.action = ACT_SEND_REQ;
			r.out_msg_type = OMT_ID_REQ;
			r.out_ri = ev.random_ri;
			r.out_ai = BROADCAST_TEI;
		end
		r.tei_assigned = holds_tei;
		r.current_tei = own_tei;
		r.request_pending = pending_req;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	function automatic item_t mk_event(input logic [2:0] op, input logic [7:0] mt,
			input logic [15:0] ri, input logic [6:0] ai, input logic [7:0] ctrl,
			input logic [7:0] ent, input logic short_f, input logic [15:0] rnd);
		item_t ev;
		ev.opcode = op;
		ev.msg_type = mt;
		ev.ref_number = ri;
		ev.ai_value = ai;
		ev.control_byte = ctrl;
		ev.entity_id = ent;
		ev.too_short = short_f;
		ev.random_ri = rnd;
		return ev;
	endfunction

	// Well-formed management frame: UI control, management entity, full length.
	function automatic item_t ui_frame(input logic [7:0] mt, input logic [15:0] ri,
			input logic [6:0] ai, input logic [15:0] rnd);
		return mk_event(OP_RX_FRAME, mt, ri, ai, UI_CONTROL, MGMT_ENTITY, 1'b0, rnd);
	endfunction

	// Mostly sensible traffic drawn from the pools, with full-range noise mixed in.
	function automatic item_t random_event();
		item_t       ev;
		int unsigned pick;
		ev.opcode = 3'($urandom_range(4));
		ev.msg_type = 8'($urandom_range(255));
		ev.ref_number = 16'($urandom_range(65535));
		ev.ai_value = 7'($urandom_range(127));
		ev.control_byte = 8'($urandom_range(255));
		ev.entity_id = 8'($urandom_range(255));
		ev.too_short = 1'($urandom_range(1));
		ev.random_ri = 16'($urandom_range(65535));
		pick = $urandom_range(99);
		if (pick < 8)
			ev.opcode = OP_ASSIGN_IND;
		else if (pick < 45)
			ev.opcode = OP_TICK;
		else if (pick < 85)
			ev.opcode = OP_RX_FRAME;
		else if (pick < 91)
			ev.opcode = OP_STATIC;
		else if (pick < 97)
			ev.opcode = OP_LOCAL_REM;
		else
			ev.opcode = 3'($urandom_range(7));
		if ($urandom_range(99) < 70)
			ev.random_ri = ri_pool[2'($urandom_range(3))];
		if ($urandom_range(99) < 70)
			ev.ref_number = ri_pool[2'($urandom_range(3))];
		if ($urandom_range(99) < 75)
			ev.ai_value = tei_pool[2'($urandom_range(3))];
		if (ev.opcode == OP_RX_FRAME && $urandom_range(99) < 85) begin
			ev.too_short = 1'b0;
			ev.control_byte = $urandom_range(1) ? UI_CONTROL : (UI_CONTROL | 8'h10);
			ev.entity_id = MGMT_ENTITY;
			pick = $urandom_range(99);
			if (pick < 40)
				ev.msg_type = MT_ID_ASSIGNED;
			else if (pick < 60)
				ev.msg_type = MT_CHECK_REQ;
			else if (pick < 75)
				ev.msg_type = MT_REMOVE;
			else if (pick < 95)
				ev.msg_type = 8'($urandom_range(7, 1));
		end
		return ev;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("ERROR result %0d: %s got %0h expected %0h", results_seen, what, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Driver: hold the payload until the transfer, then advance to the next event.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				awaited_actions.push_back(tei_response(driven_event));
			if (!in_valid || !in_stall) begin
				if (queued_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					driven_event = queued_events.pop_front();
					events_sent++;
					in_valid <= 1'b1;
					opcode <= driven_event.opcode;
					msg_type <= driven_event.msg_type;
					ref_number <= driven_event.ref_number;
					ai_value <= driven_event.ai_value;
					control_byte <= driven_event.control_byte;
					entity_id <= driven_event.entity_id;
					too_short <= driven_event.too_short;
					random_ri <= driven_event.random_ri;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each result transfer with the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t seen;
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				seen.action = action_t'(action);
				seen.out_msg_type = out_msg_type;
				seen.out_ri = out_ri;
				seen.out_ai = out_ai;
				seen.tei_assigned = tei_assigned;
				seen.current_tei = current_tei;
				seen.request_pending = request_pending;
				if (awaited_actions.size() == 0) begin
					report_mismatch("result with nothing predicted, action",
						16'(seen.action), 16'd0);
				end else begin
					want = awaited_actions.pop_front();
					if (seen.action !== want.action)
						report_mismatch("action", 16'(seen.action), 16'(want.action));
					if (seen.out_msg_type !== want.out_msg_type)
						report_mismatch("out_msg_type", 16'(seen.out_msg_type),
							16'(want.out_msg_type));
					if (seen.out_ri !== want.out_ri)
						report_mismatch("out_ri", seen.out_ri, want.out_ri);
					if (seen.out_ai !== want.out_ai)
						report_mismatch("out_ai", 16'(seen.out_ai), 16'(want.out_ai));
					if (seen.tei_assigned !== want.tei_assigned)
						report_mismatch("tei_assigned", 16'(seen.tei_assigned),
							16'(want.tei_assigned));
					if (seen.current_tei !== want.current_tei)
						report_mismatch("current_tei", 16'(seen.current_tei),
							16'(want.current_tei));
					if (seen.request_pending !== want.request_pending)
						report_mismatch("request_pending", 16'(seen.request_pending),
							16'(want.request_pending));
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer: reset, then phases of register settings and traffic.
	// ------------------------------------------------------------------
	initial begin
		int p;
		int i;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		for (p = 0; p < N_PHASES; p++) begin
			// The block is idle here: all events sent and all results back.
			if (p != 0) begin
				@(posedge clk);
				cfg_we <= 1'b1;
				cfg_index <= CFG_RETRY_TIMEOUT;
				cfg_wdata <= PHASE_TIMEOUT[p];
				@(posedge clk);
				cfg_index <= CFG_MAX_ATTEMPTS;
				cfg_wdata <= {12'd0, PHASE_ATTEMPTS[p]};
				@(posedge clk);
				cfg_we <= 1'b0;
				retry_ticks = PHASE_TIMEOUT[p];
				attempt_limit = PHASE_ATTEMPTS[p];
			end

			// Rotate through: no idling, sender idle, receiver stalling, both.
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase

			tei_pool[0] = BROADCAST_TEI;
			for (i = 0; i < 4; i++) begin
				ri_pool[i] = 16'($urandom_range(65535));
				if (i != 0)
					tei_pool[i] = 7'($urandom_range(126));
			end

			if (p == 0) begin
				// Nothing held yet: remove and tick are ignored.
				queued_events.push_back(mk_event(OP_LOCAL_REM, 8'd0, 16'd0, BROADCAST_TEI,
					8'd0, 8'd0, 1'b0, 16'd0));
				queued_events.push_back(mk_event(OP_TICK, 8'hff, 16'hffff, 7'h7f, 8'hff, 8'hff,
					1'b1, 16'hffff));
				// Frame filter: short, not UI, wrong entity.
				queued_events.push_back(mk_event(OP_RX_FRAME, MT_ID_ASSIGNED, 16'd0, 7'd0,
					UI_CONTROL, MGMT_ENTITY, 1'b1, 16'd0));
				queued_events.push_back(mk_event(OP_RX_FRAME, MT_CHECK_REQ, 16'd0, 7'd0,
					8'h01, MGMT_ENTITY, 1'b0, 16'd0));
				queued_events.push_back(mk_event(OP_RX_FRAME, MT_CHECK_REQ, 16'd0, 7'd0,
					UI_CONTROL, 8'h0e, 1'b0, 16'd0));
				// Assignment with no request outstanding.
				queued_events.push_back(ui_frame(MT_ID_ASSIGNED, 16'd0, 7'd5, 16'd0));
				// Request, one countdown tick, wrong Ri, then a match with the poll bit set.
				queued_events.push_back(mk_event(OP_ASSIGN_IND, 8'd0, 16'd0, 7'd0, 8'd0, 8'd0,
					1'b0, 16'hffff));
				queued_events.push_back(mk_event(OP_TICK, 8'd0, 16'd0, 7'd0, 8'd0, 8'd0,
					1'b0, 16'd0));
				queued_events.push_back(ui_frame(MT_ID_ASSIGNED, 16'h0000, 7'd0, 16'd0));
				queued_events.push_back(mk_event(OP_RX_FRAME, MT_ID_ASSIGNED, 16'hffff, 7'd0,
					UI_CONTROL | 8'h10, MGMT_ENTITY, 1'b0, 16'd0));
				// Check requests: broadcast, own TEI, someone else.
				queued_events.push_back(ui_frame(MT_CHECK_REQ, 16'd0, BROADCAST_TEI, 16'h0000));
				queued_events.push_back(ui_frame(MT_CHECK_REQ, 16'd0, 7'd0, 16'hffff));
				queued_events.push_back(ui_frame(MT_CHECK_REQ, 16'd0, 7'd5, 16'h1234));
				// Duplicate assignment of our own TEI.
				queued_events.push_back(ui_frame(MT_ID_ASSIGNED, 16'h5555, 7'd0, 16'd0));
				queued_events.push_back(mk_event(OP_STATIC, 8'd0, 16'd0, 7'd126, 8'd0, 8'd0,
					1'b0, 16'd0));
				queued_events.push_back(ui_frame(MT_REMOVE, 16'd0, BROADCAST_TEI, 16'd0));
				queued_events.push_back(mk_event(OP_STATIC, 8'd0, 16'd0, 7'd64, 8'd0, 8'd0,
					1'b0, 16'd0));
				queued_events.push_back(mk_event(OP_LOCAL_REM, 8'd0, 16'd0, 7'd64, 8'd0, 8'd0,
					1'b0, 16'd0));
				// Held TEI 0; types with no user-side meaning do nothing.
				queued_events.push_back(mk_event(OP_STATIC, 8'd0, 16'd0, 7'd0, 8'd0, 8'd0,
					1'b0, 16'd0));
				queued_events.push_back(ui_frame(8'd1, 16'd0, 7'd0, 16'd0));
				queued_events.push_back(ui_frame(8'd3, 16'd0, 7'd0, 16'd0));
				queued_events.push_back(ui_frame(8'd5, 16'd0, 7'd0, 16'd0));
				queued_events.push_back(ui_frame(8'd7, 16'd0, 7'd0, 16'd0));
				queued_events.push_back(ui_frame(8'd255, 16'd0, BROADCAST_TEI, 16'd0));
				queued_events.push_back(mk_event(OP_UNDEFINED, MT_REMOVE, 16'd0, BROADCAST_TEI,
					UI_CONTROL, MGMT_ENTITY, 1'b0, 16'd0));
			end

			repeat (EVENTS_PER_PHASE) queued_events.push_back(random_event());

			// Drain: every event transferred and its result collected.
			while (queued_events.size() != 0 || results_seen < events_sent)
				@(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end

		// Catch any stray result after the last one.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_actions.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
